FILE: design/rtss_pkg.sv
// Package for the resistive touch scan sequencer.
// Holds ADC width, accumulator limits, drive codes, result type and the phase drive table.
// No dependencies.
package rtss_pkg;

	localparam int unsigned ADC_BITS = 10;
	localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

	localparam int unsigned CNT_W = 7;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned SUM_W = 17;
	localparam int unsigned POS_W = 15;
	localparam int unsigned PHASE_W = 3;

	localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(64);
	localparam logic [CNT_W-1:0] COORD_RESET = CNT_W'(32);
	localparam logic [CNT_W-1:0] PRESSURE_RESET = CNT_W'(16);

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// configuration register indexes
	localparam logic REG_COORD_SAMPLES = 1'b0;
	localparam logic REG_PRESSURE_SAMPLES = 1'b1;

	// scan phases
	localparam logic [PHASE_W-1:0] PH_X_FWD = 3'd0;
	localparam logic [PHASE_W-1:0] PH_X_REV = 3'd1;
	localparam logic [PHASE_W-1:0] PH_Y_FWD = 3'd2;
	localparam logic [PHASE_W-1:0] PH_Y_REV = 3'd3;
	localparam logic [PHASE_W-1:0] PH_P_A = 3'd4;
	localparam logic [PHASE_W-1:0] PH_P_B = 3'd5;
	localparam logic [PHASE_W-1:0] PH_P_C = 3'd6;
	localparam logic [PHASE_W-1:0] PH_P_D = 3'd7;

	typedef enum logic [1:0] {
		DRV_HIZ  = 2'd0,
		DRV_LOW  = 2'd1,
		DRV_HIGH = 2'd2
	} drive_code_t;

	typedef enum logic [1:0] {
		SNS_X1 = 2'd0,
		SNS_X2 = 2'd1,
		SNS_Y1 = 2'd2,
		SNS_Y2 = 2'd3
	} sense_t;

	typedef struct packed {
		sense_t      sense;
		drive_code_t y2;
		drive_code_t y1;
		drive_code_t x2;
		drive_code_t x1;
	} drive_t;

	typedef struct packed {
		logic [SUM_W-1:0]   pressure;
		logic [POS_W-1:0]   y_pos;
		logic [POS_W-1:0]   x_pos;
		logic               frame_done;
		drive_t             drv;
		logic [PHASE_W-1:0] phase;
	} result_t;

	function automatic drive_t phase_drive(input logic [PHASE_W-1:0] ph);
		drive_t d;
		d = '{sense: SNS_X1, y2: DRV_HIZ, y1: DRV_HIZ, x2: DRV_HIZ, x1: DRV_HIZ};
		unique case (ph)
			PH_X_FWD: begin
				d.y1 = DRV_LOW;  d.y2 = DRV_HIGH; d.sense = SNS_X2;
			end
			PH_X_REV: begin
				d.y1 = DRV_HIGH; d.y2 = DRV_LOW;  d.sense = SNS_X2;
			end
			PH_Y_FWD: begin
				d.x1 = DRV_LOW;  d.x2 = DRV_HIGH; d.sense = SNS_Y2;
			end
			PH_Y_REV: begin
				d.x1 = DRV_HIGH; d.x2 = DRV_LOW;  d.sense = SNS_Y2;
			end
			PH_P_A: begin
				d.x1 = DRV_HIGH; d.x2 = DRV_HIGH; d.y1 = DRV_LOW; d.sense = SNS_Y2;
			end
			PH_P_B: begin
				d.x1 = DRV_HIGH; d.x2 = DRV_HIGH; d.y2 = DRV_LOW; d.sense = SNS_Y1;
			end
			PH_P_C: begin
				d.y1 = DRV_HIGH; d.y2 = DRV_HIGH; d.x1 = DRV_LOW; d.sense = SNS_X2;
			end
			PH_P_D: begin
				d.y1 = DRV_HIGH; d.y2 = DRV_HIGH; d.x2 = DRV_LOW; d.sense = SNS_X1;
			end
			default: d = d;
		endcase
		return d;
	endfunction

endpackage

FILE: design/rtss_scan.sv
// Scan state of the touch sequencer: phase, sample index, accumulators and held results.
// Computes the result for one conversion and advances the state on step. Uses rtss_pkg.
module rtss_scan
	import rtss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [9:0]          adc_value,
	input  logic [CNT_W-1:0]    coord_samples,
	input  logic [CNT_W-1:0]    pressure_samples,
	output result_t             result
);

	logic [PHASE_W-1:0] phase_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SUM_W-1:0]   coord_sum_q;
	logic [SUM_W-1:0]   pressure_sum_q;
	logic [POS_W-1:0]   x_hold_q;
	logic [POS_W-1:0]   y_hold_q;
	logic [SUM_W-1:0]   pressure_hold_q;

	logic                is_coord;
	logic                reversed;
	logic [CNT_W-1:0]    cnt_raw;
	logic [CNT_W-1:0]    cnt;
	logic                keep;
	logic                last;
	logic [ADC_BITS-1:0] sample;
	logic [ADC_BITS-1:0] val;
	logic [SUM_W-1:0]    acc;
	logic [SUM_W:0]      acc_add;
	logic [SUM_W-1:0]    acc_new;
	logic [SUM_W-1:0]    coord_next;
	logic [SUM_W-1:0]    pressure_next;
	logic [POS_W-1:0]    half_pos;
	logic [PHASE_W-1:0]  phase_next;
	logic                hold_x;
	logic                hold_y;
	logic                hold_p;

	assign is_coord = ~phase_q[2];
	assign reversed = (phase_q == PH_X_REV) || (phase_q == PH_Y_REV);
	assign cnt_raw  = is_coord ? coord_samples : pressure_samples;

	always_comb begin
		priority if (cnt_raw < CNT_MIN) begin
			cnt = CNT_MIN;
		end else if (cnt_raw > CNT_MAX) begin
			cnt = CNT_MAX;
		end else begin
			cnt = cnt_raw;
		end
	end

	// lower half of each phase is settling time
	assign keep = {1'b0, idx_q} >= (cnt >> 1);
	assign last = ({1'b0, idx_q} + CNT_W'(1)) >= cnt;

	assign sample  = ADC_BITS'(adc_value);
	assign val     = reversed ? (ADC_MAX - sample) : sample;
	assign acc     = is_coord ? coord_sum_q : pressure_sum_q;
	assign acc_add = {1'b0, acc} + (SUM_W+1)'(val);
	assign acc_new = acc_add[SUM_W] ? SUM_MAX : acc_add[SUM_W-1:0];

	assign coord_next    = (keep && is_coord) ? acc_new : coord_sum_q;
	assign pressure_next = (keep && !is_coord) ? acc_new : pressure_sum_q;

	assign half_pos = coord_next[SUM_W-1] ? POS_MAX : coord_next[POS_W:1];

	assign hold_x = last && (phase_q == PH_X_REV);
	assign hold_y = last && (phase_q == PH_Y_REV);
	assign hold_p = last && (phase_q == PH_P_D);
	assign phase_next = last ? phase_q + PHASE_W'(1) : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_X_FWD;
			idx_q           <= '0;
			coord_sum_q     <= '0;
			pressure_sum_q  <= '0;
			x_hold_q        <= '0;
			y_hold_q        <= '0;
			pressure_hold_q <= '0;
		end else if (step) begin
			phase_q        <= phase_next;
			idx_q          <= last ? '0 : idx_q + IDX_W'(1);
			coord_sum_q    <= (hold_x || hold_y) ? '0 : coord_next;
			pressure_sum_q <= hold_p ? '0 : pressure_next;
			if (hold_x) begin
				x_hold_q <= half_pos;
			end
			if (hold_y) begin
				y_hold_q <= half_pos;
			end
			if (hold_p) begin
				pressure_hold_q <= pressure_next;
			end
		end
	end

	always_comb begin
		result.phase      = phase_next;
		result.drv        = phase_drive(phase_next);
		result.frame_done = hold_p;
		result.x_pos      = hold_x ? half_pos : x_hold_q;
		result.y_pos      = hold_y ? half_pos : y_hold_q;
		result.pressure   = hold_p ? pressure_next : pressure_hold_q;
	end

endmodule

FILE: design/resistive_touch_scan_sequencer_top.sv
// Top level of the four-wire resistive touch scan sequencer.
// Stream ports, configuration registers, input and result registers; uses rtss_pkg and rtss_scan.
//
// Each item on the slave stream is one ADC conversion of the electrode currently sensed; each
// item on the master stream tells the drive of X1, X2, Y1, Y2 and the ADC channel for the next
// conversion, with the held X, Y and pressure results and a frame-done flag on tlast. One item
// is taken every clock cycle unless the input side stalls; the input register holds it until the
// accumulate-and-advance logic loads its result into the result register. The input side stalls
// only while both the input and the result register hold items and the result is not being taken.
// Sample counts are written through cfg_we/cfg_index/cfg_data; the user must write them only while
// the stream is idle (the block does not enforce this); they count in the current phase at once.
module resistive_touch_scan_sequencer_top
	import rtss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // [9:0] adc_value
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata,   // next_phase, x1_drive, x2_drive, y1_drive, y2_drive,
	                                    // sense_electrode, x_position, y_position, pressure
	output logic             m_tlast,   // frame_done
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_data
);

	logic [CNT_W-1:0] coord_samples_q;
	logic [CNT_W-1:0] pressure_samples_q;
	logic             valid_s1;
	logic [9:0]       adc_s1;
	logic             valid_s2;
	result_t          result_s2;
	result_t          result;
	logic             advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_samples_q    <= COORD_RESET;
			pressure_samples_q <= PRESSURE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COORD_SAMPLES:    coord_samples_q <= cfg_data;
				REG_PRESSURE_SAMPLES: pressure_samples_q <= cfg_data;
				default:              coord_samples_q <= coord_samples_q;
			endcase
		end
	end

	// move the held item on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			adc_s1 <= s_tdata[9:0];
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	rtss_scan u_scan (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.adc_value        (adc_s1),
		.coord_samples    (coord_samples_q),
		.pressure_samples (pressure_samples_q),
		.result           (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tlast  = result_s2.frame_done;
	assign m_tdata  = {4'b0, result_s2.pressure, result_s2.y_pos, result_s2.x_pos,
		result_s2.drv, result_s2.phase};

endmodule

FILE: design/rtss_checker.sv
// Port-level checks for the touch scan sequencer, bound to the top level.
// Sees only the top-level ports; uses no package.
module rtss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [6:0]  cfg_data
);

	// a finished frame always hands over to X forward
	a_frame_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[2:0] == 3'd0)
		else $error("frame done without return to first phase");

	// the input side only stalls behind a full, blocked result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output side is free");

	// no electrode ever gets the unused drive code
	a_drive_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4:3] != 2'd3 && m_tdata[6:5] != 2'd3 &&
			m_tdata[8:7] != 2'd3 && m_tdata[10:9] != 2'd3)
		else $error("invalid electrode drive code");

	// a blocked result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

endmodule

bind resistive_touch_scan_sequencer_top rtss_checker u_rtss_checker (.*);
